[sv/dst_pkg.sv]
// shared constants, codes and types of the descriptor slot table
package dst_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int PTR_W = $clog2(SLOT_COUNT + 1);
	localparam int KEY_W = 64;
	localparam int OP_W = 2;
	localparam int SLOT_W = 6;
	localparam int IDX_W = 6;
	localparam int ST_W = 2;

	localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(SLOT_COUNT);

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND = 2'd2;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [KEY_W-1:0] wr_data;
		logic rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

endpackage

[sv/dst_key_mem.sv]
// key memory of the slot table with per-slot valid bits for reset clearing
module dst_key_mem
	import dst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  mem_req_t req,
	output logic [KEY_W-1:0] rd_data
);

	logic [KEY_W-1:0] mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] vld_q;
	logic [KEY_W-1:0] mem_data_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_data_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? mem_data_q : '0;

endmodule

[sv/dst_ctrl.sv]
// sequencer for allocate, delete and find, with the free pointer and slot scan
module dst_ctrl
	import dst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [OP_W-1:0] operation,
	input  logic [KEY_W-1:0] key_value,
	input  logic [SLOT_W-1:0] slot_index,
	output logic out_valid,
	input  logic out_ready,
	output logic [ST_W-1:0] status,
	output logic [IDX_W-1:0] result_index,
	output mem_req_t mem_req,
	input  logic [KEY_W-1:0] rd_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_OUT
	} state_t;

	state_t state_q;
	logic [PTR_W-1:0] ptr_q;
	logic [PTR_W-1:0] rd_addr_q;
	logic chk_vld_s1;
	logic [PTR_W-1:0] chk_addr_s1;
	logic find_q;
	logic [KEY_W-1:0] target_q;
	logic [ST_W-1:0] res_status_q;
	logic [IDX_W-1:0] res_index_q;
	logic out_valid_q;
	logic [ST_W-1:0] out_status_q;
	logic [IDX_W-1:0] out_index_q;

	logic accept;
	logic slot_ok;
	logic slot_below;
	logic have_free;
	logic issue;
	logic hit;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign slot_ok = 32'(slot_index) < 32'(SLOT_COUNT);
	assign slot_below = 32'(slot_index) < 32'(ptr_q);
	assign have_free = ptr_q < PTR_FULL;
	assign issue = rd_addr_q < PTR_FULL;
	assign hit = chk_vld_s1 && (rd_data == target_q);

	always_comb begin
		mem_req.wr_en = 1'b0;
		mem_req.wr_addr = ADDR_W'(ptr_q);
		mem_req.wr_data = key_value;
		if (accept && operation == OP_ALLOC && have_free) begin
			mem_req.wr_en = 1'b1;
		end else if (accept && operation == OP_DELETE && slot_ok) begin
			mem_req.wr_en = 1'b1;
			mem_req.wr_addr = ADDR_W'(slot_index);
			mem_req.wr_data = '0;
		end
		mem_req.rd_en = (state_q == S_SCAN) && issue && !hit;
		mem_req.rd_addr = ADDR_W'(rd_addr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q <= '0;
			rd_addr_q <= '0;
			chk_vld_s1 <= 1'b0;
			chk_addr_s1 <= '0;
			find_q <= 1'b0;
			target_q <= '0;
			res_status_q <= ST_INVALID;
			res_index_q <= '0;
			out_valid_q <= 1'b0;
			out_status_q <= ST_INVALID;
			out_index_q <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_status_q <= ST_INVALID;
						res_index_q <= '0;
						chk_vld_s1 <= 1'b0;
						state_q <= S_OUT;
						case (operation)
							OP_ALLOC: begin
								if (!have_free) begin
									res_status_q <= ST_FULL;
								end else begin
									res_status_q <= ST_OK;
									res_index_q <= IDX_W'(ptr_q);
									if (key_value != '0) begin
										find_q <= 1'b0;
										target_q <= '0;
										rd_addr_q <= ptr_q + PTR_W'(1);
										state_q <= S_SCAN;
									end
								end
							end
							OP_DELETE: begin
								if (slot_ok) begin
									res_status_q <= ST_OK;
									res_index_q <= IDX_W'(slot_index);
									if (slot_below) begin
										ptr_q <= PTR_W'(slot_index);
									end
								end
							end
							OP_FIND: begin
								if (key_value != '0) begin
									find_q <= 1'b1;
									target_q <= key_value;
									rd_addr_q <= '0;
									state_q <= S_SCAN;
								end
							end
							default: begin
								res_status_q <= ST_INVALID;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						if (find_q) begin
							res_status_q <= ST_OK;
							res_index_q <= IDX_W'(chk_addr_s1);
						end else begin
							ptr_q <= chk_addr_s1;
						end
						state_q <= S_OUT;
					end else if (!issue) begin
						if (!find_q) begin
							ptr_q <= PTR_FULL;
						end
						state_q <= S_OUT;
					end else begin
						chk_vld_s1 <= 1'b1;
						chk_addr_s1 <= rd_addr_q;
						rd_addr_q <= rd_addr_q + PTR_W'(1);
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_status_q <= res_status_q;
						out_index_q <= res_index_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign result_index = out_index_q;

endmodule

[sv/descriptor_slot_table_top.sv]
// top level of the descriptor slot table: control sequencer and key memory
// One request is worked at a time. Delete, allocate into a full table,
// allocate of key zero, find of key zero and unknown operations skip the
// scan: their result goes from the result register to the output register.
// A find of a nonzero key reads one slot per cycle from slot 0 through the
// single read port of the key memory until it hits or passes the last slot.
// An allocate of a nonzero key writes the key, then scans upward from the
// slot after it for the next free one before it answers; the next request
// is taken only once the result has moved to the output register. The table
// is cleared by per-slot valid bits at reset, so no clearing pass is needed.
module descriptor_slot_table_top
	import dst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [OP_W-1:0] operation,
	input  logic [KEY_W-1:0] key_value,
	input  logic [SLOT_W-1:0] slot_index,
	output logic out_valid,
	input  logic out_ready,
	output logic [ST_W-1:0] status,
	output logic [IDX_W-1:0] result_index
);

	mem_req_t mem_req;
	logic [KEY_W-1:0] rd_data;

	dst_key_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	dst_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.key_value    (key_value),
		.slot_index   (slot_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.result_index (result_index),
		.mem_req      (mem_req),
		.rd_data      (rd_data)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one still in progress");

	a_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> in_valid && in_ready)
		else $error("key memory written outside a request");

	a_read_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.rd_en |-> !in_ready && !mem_req.wr_en)
		else $error("scan read while idle or during a write");

	a_fail_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> result_index == '0)
		else $error("nonzero index on failed request");

endmodule

[tb/tb.sv]
// self-checking testbench of the descriptor slot table: directed and random requests against a slot model
`timescale 1ns / 100ps

module tb
	import dst_pkg::*;
();

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int GAP_MAX = 13;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [OP_W-1:0] operation;
	logic [KEY_W-1:0] key_value;
	logic [SLOT_W-1:0] slot_index;
	logic out_valid;
	logic out_ready;
	logic [ST_W-1:0] status;
	logic [IDX_W-1:0] result_index;

	logic [KEY_W-1:0] slot_keys [SLOT_COUNT];
	int free_ptr;
	logic [ST_W-1:0] exp_status_q [$];
	logic [IDX_W-1:0] exp_index_q [$];

	int in_gap_max;
	int out_stall_max;
	int error_count;
	int cycle_count;
	int alloc_count;
	int delete_count;
	int find_count;
	int full_count;
	int hit_count;
	int other_count;

	descriptor_slot_table_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.key_value(key_value),
		.slot_index(slot_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.result_index(result_index)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// slot model: computes the answer of one request and updates the table
	function automatic void predict_answer(input logic [OP_W-1:0] op,
		input logic [KEY_W-1:0] key, input logic [SLOT_W-1:0] slot);
		logic [ST_W-1:0] st;
		logic [IDX_W-1:0] idx;
		st = ST_INVALID;
		idx = '0;
		case (op)
			OP_ALLOC: begin
				alloc_count++;
				if (free_ptr >= SLOT_COUNT) begin
					st = ST_FULL;
					full_count++;
				end else begin
					slot_keys[free_ptr] = key;
					st = ST_OK;
					idx = IDX_W'(free_ptr);
					while (free_ptr < SLOT_COUNT && slot_keys[free_ptr] != '0)
						free_ptr++;
				end
			end
			OP_DELETE: begin
				delete_count++;
				if (int'(slot) < SLOT_COUNT) begin
					slot_keys[slot] = '0;
					if (int'(slot) < free_ptr)
						free_ptr = int'(slot);
					st = ST_OK;
					idx = IDX_W'(slot);
				end
			end
			OP_FIND: begin
				find_count++;
				if (key != '0) begin
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (st != ST_OK && slot_keys[i] == key) begin
							st = ST_OK;
							idx = IDX_W'(i);
						end
					end
				end
				if (st == ST_OK)
					hit_count++;
			end
			default: begin
				other_count++;
			end
		endcase
		exp_status_q.push_back(st);
		exp_index_q.push_back(idx);
	endfunction

	function automatic logic [KEY_W-1:0] draw_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		else if (r < 24)
			return KEY_W'($urandom_range(1, 8));
		else
			return {$urandom, $urandom};
	endfunction

	task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
		input logic [SLOT_W-1:0] slot);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		operation = op;
		key_value = key;
		slot_index = slot;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_answer(op, key, slot);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (exp_status_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_request(OP_FIND, 64'd1, 6'd0);
		send_request(OP_FIND, '0, 6'd63);
		send_request(OP_ALLOC, '1, 6'd63);
		send_request(OP_ALLOC, '0, 6'd0);
		send_request(OP_ALLOC, 64'd1, 6'd21);
		send_request(OP_ALLOC, '1, 6'd42);
		send_request(OP_FIND, '1, 6'd0);
		send_request(OP_FIND, 64'd1, 6'd63);
		send_request(OP_FIND, '0, 6'd0);
		send_request(OP_DELETE, '1, 6'd0);
		send_request(OP_DELETE, '0, 6'd63);
		send_request(OP_FIND, '1, 6'd0);
		send_request(OP_ALLOC, 64'h8000_0000_0000_0000, 6'd0);
		send_request(OP_UNUSED, '1, 6'd63);
		send_request(OP_UNUSED, '0, 6'd0);
		send_request(OP_DELETE, '1, 6'd1);
		send_request(OP_ALLOC, 64'h5555_5555_5555_5555, 6'd42);
		send_request(OP_ALLOC, 64'haaaa_aaaa_aaaa_aaaa, 6'd21);
		send_request(OP_FIND, 64'haaaa_aaaa_aaaa_aaaa, 6'd0);
		send_request(OP_FIND, 64'h8000_0000_0000_0000, 6'd0);
	endtask

	task automatic test_fill_and_full();
		while (free_ptr < SLOT_COUNT)
			send_request(OP_ALLOC, {$urandom, $urandom} | 64'd1, 6'($urandom));
		repeat (3) send_request(OP_ALLOC, {$urandom, $urandom}, 6'($urandom));
		send_request(OP_FIND, slot_keys[SLOT_COUNT-1], 6'($urandom));
		wait_drained();
		send_request(OP_DELETE, {$urandom, $urandom}, 6'd37);
		send_request(OP_ALLOC, 64'hdead_beef_0000_0001, 6'($urandom));
		send_request(OP_ALLOC, 64'hdead_beef_0000_0002, 6'($urandom));
		send_request(OP_DELETE, {$urandom, $urandom}, 6'(SLOT_COUNT - 1));
		send_request(OP_ALLOC, 64'hdead_beef_0000_0003, 6'($urandom));
		wait_drained();
	endtask

	task automatic test_random(input int count);
		int alloc_w;
		int r;
		logic [OP_W-1:0] op;
		logic [KEY_W-1:0] key;
		for (int n = 0; n < count; n++) begin
			if (n % 60 == 0) begin
				alloc_w = $urandom_range(25, 70);
				in_gap_max = ((n / 60) % 3 == 1) ? 0 : GAP_MAX;
				out_stall_max = ((n / 60) % 3 == 2) ? 0 : GAP_MAX;
			end
			r = $urandom_range(0, 99);
			key = draw_key();
			if (r < alloc_w) begin
				op = OP_ALLOC;
			end else if (r < alloc_w + 20) begin
				op = OP_DELETE;
			end else if (r < 97) begin
				op = OP_FIND;
				if ($urandom_range(0, 9) < 7)
					key = slot_keys[$urandom_range(0, SLOT_COUNT - 1)];
			end else begin
				op = OP_UNUSED;
			end
			send_request(op, key, 6'($urandom));
		end
		in_gap_max = GAP_MAX;
		out_stall_max = GAP_MAX;
	endtask

	task automatic test_drain();
		for (int i = SLOT_COUNT - 1; i >= 0; i--)
			send_request(OP_DELETE, {$urandom, $urandom}, 6'(i));
		repeat (3) send_request(OP_FIND, draw_key() | 64'd1, 6'($urandom));
		send_request(OP_ALLOC, {$urandom, $urandom}, 6'($urandom));
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ALLOC;
		key_value = '0;
		slot_index = '0;
		in_gap_max = GAP_MAX;
		out_stall_max = GAP_MAX;
		error_count = 0;
		alloc_count = 0;
		delete_count = 0;
		find_count = 0;
		full_count = 0;
		hit_count = 0;
		other_count = 0;
		for (int i = 0; i < SLOT_COUNT; i++)
			slot_keys[i] = '0;
		free_ptr = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_fill_and_full();
		test_random(340);
		test_drain();

		wait_drained();
		repeat (SLOT_COUNT + 16) @(posedge clk);
		if (exp_status_q.size() != 0) begin
			$display("%0t %0d expected results never arrived", $time, exp_status_q.size());
			error_count++;
		end
		$display("covered %0d allocates (%0d into a full table), %0d deletes,",
			alloc_count, full_count, delete_count);
		$display("%0d finds (%0d hits) and %0d unknown operations", find_count, hit_count,
			other_count);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, out_stall_max);
			@(negedge clk);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (exp_status_q.size() == 0) begin
				$display("%0t unexpected result: status %0d index %0d", $time, status,
					result_index);
				error_count++;
			end else begin
				if (status !== exp_status_q[0]) begin
					$display("%0t status mismatch: expected %0d actual %0d", $time,
						exp_status_q[0], status);
					error_count++;
				end
				if (result_index !== exp_index_q[0]) begin
					$display("%0t result_index mismatch: expected %0d actual %0d", $time,
						exp_index_q[0], result_index);
					error_count++;
				end
				void'(exp_status_q.pop_front());
				void'(exp_index_q.pop_front());
			end
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("%0t timeout after %0d cycles", $time, cycle_count);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule
